@@ sv/bitmap_frame_allocator_defines.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define BFA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define BFA_ASSERT(lbl, clk, rstn, prop)
`define BFA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/bfa_pkg.sv @@
`default_nettype none
package bfa_pkg;
    localparam int FRAME_BYTES_DEF = 4096;
    localparam int FRAME_COUNT_DEF = 262144;
    localparam int WORD_BITS = 32;
    localparam int BIT_W = 5;
    localparam int ADDR_W = 32;
    localparam int CNT_W = 19;
    localparam int FADDR_W = 30;

    localparam logic [1:0] OP_ALLOC     = 2'd0;
    localparam logic [1:0] OP_FREE      = 2'd1;
    localparam logic [1:0] OP_MARK_FREE = 2'd2;
    localparam logic [1:0] OP_MARK_USED = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_LIMIT = 3'd2;
    localparam logic [2:0] ST_ALIGN = 3'd3;
    localparam logic [2:0] ST_FREE  = 3'd4;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] range_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [FADDR_W-1:0] frame_address;
        logic [CNT_W-1:0]   free_count;
        logic [CNT_W-1:0]   used_count;
    } t_out_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic [BIT_W-1:0]     lo;
        logic [BIT_W-1:0]     hi;
        logic                 set;
        logic                 find;
    } t_wu_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic [WORD_BITS-1:0] chg;
        logic [BIT_W-1:0]     zero_idx;
    } t_wu_rsp;

    function automatic logic [BIT_W:0] popcount_word(input logic [WORD_BITS-1:0] v);
        logic [BIT_W:0] s;
        s = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            s = s + (BIT_W + 1)'(v[k]);
        end
        return s;
    endfunction
endpackage
`default_nettype wire

@@ sv/bfa_word_unit.sv @@
`default_nettype none
module bfa_word_unit (
    input  bfa_pkg::t_wu_req i_req,
    output bfa_pkg::t_wu_rsp o_rsp
);
    import bfa_pkg::*;

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] range_m;
    logic [BIT_W-1:0]     idx;

    always_comb begin
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!i_req.data[k]) begin
                idx = BIT_W'(k);
            end
        end
        for (int k = 0; k < WORD_BITS; k++) begin
            range_m[k] = (BIT_W'(k) >= i_req.lo) && (BIT_W'(k) <= i_req.hi);
        end
        if (i_req.find) begin
            mask = {{(WORD_BITS - 1){1'b0}}, ~&i_req.data} << idx;
        end else begin
            mask = range_m;
        end
        o_rsp.zero_idx = idx;
        if (i_req.set) begin
            o_rsp.data = i_req.data | mask;
            o_rsp.chg  = mask & ~i_req.data;
        end else begin
            o_rsp.data = i_req.data & ~mask;
            o_rsp.chg  = mask & i_req.data;
        end
    end
endmodule
`default_nettype wire

@@ sv/bfa_seq.sv @@
`default_nettype none
`include "bitmap_frame_allocator_defines.svh"
module bfa_seq #(
    parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF,
    parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bfa_pkg::t_in_item  i_in_data,
    output logic               o_in_ready,
    output logic               o_res_valid,
    input  logic               i_res_ack,
    output bfa_pkg::t_out_item o_res
);
    import bfa_pkg::*;

    localparam int FB_LOG  = $clog2(FRAME_BYTES);
    localparam int NWORDS  = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = $clog2(NWORDS);
    localparam int FIDX_W  = $clog2(FRAME_COUNT + 1);
    localparam int LIM_W   = ADDR_W + 5;
    localparam longint unsigned LIMIT_L = longint'(FRAME_BYTES) * longint'(FRAME_COUNT);
    localparam logic [LIM_W-1:0]   LIMIT     = LIM_W'(LIMIT_L);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);
    localparam logic [CNT_W-1:0]   TOTAL     = CNT_W'(FRAME_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_ARD, S_ACHK, S_FRD, S_FCHK,
        S_RRD, S_RMOD, S_RCNT, S_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_op;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_end;
    logic [WADDR_W-1:0]   r_waddr;
    logic [WADDR_W-1:0]   r_first_w;
    logic [WADDR_W-1:0]   r_last_w;
    logic [WADDR_W-1:0]   r_clr;
    logic [BIT_W-1:0]     r_lo;
    logic [BIT_W-1:0]     r_hi;
    logic [WORD_BITS-1:0] r_chg;
    logic [CNT_W-1:0]     r_free;
    logic [2:0]           r_status;
    logic [FADDR_W-1:0]   r_faddr;
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_mem [NWORDS];

    logic                 mem_we;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    t_wu_req              wu_req;
    t_wu_rsp              wu_rsp;
    logic [LIM_W-1:0]     addr_x;
    logic [LIM_W-1:0]     end_c;
    logic [FIDX_W-1:0]    first_f;
    logic [FIDX_W-1:0]    lastm1_f;
    logic [WADDR_W+BIT_W-1:0] alloc_f;
    logic [BIT_W:0]       chg_cnt;

    bfa_word_unit u_word_unit (
        .i_req(wu_req),
        .o_rsp(wu_rsp)
    );

    always_comb begin
        addr_x = LIM_W'(r_addr);
        if (LIM_W'(r_end) > LIMIT) begin
            end_c = LIMIT;
        end else begin
            end_c = LIM_W'(r_end);
        end
        first_f  = FIDX_W'(addr_x >> FB_LOG);
        lastm1_f = FIDX_W'((end_c - LIM_W'(1)) >> FB_LOG);
        alloc_f  = {r_waddr, wu_rsp.zero_idx};
        chg_cnt  = popcount_word(r_chg);
    end

    always_comb begin
        wu_req.data = r_rdata;
        wu_req.find = (r_state == S_ACHK);
        wu_req.set  = (r_state == S_ACHK) || ((r_state == S_RMOD) && (r_op == OP_MARK_USED));
        wu_req.lo   = (r_waddr == r_first_w) ? r_lo : '0;
        wu_req.hi   = (r_waddr == r_last_w) ? r_hi : '1;
    end

    assign mem_re = (r_state == S_ARD) || (r_state == S_FRD) || (r_state == S_RRD);
    assign mem_we = (r_state == S_CLEAR) || (r_state == S_RMOD)
                 || ((r_state == S_ACHK) && (wu_rsp.chg != '0))
                 || ((r_state == S_FCHK) && (wu_rsp.chg != '0));
    assign mem_wa = (r_state == S_CLEAR) ? r_clr : r_waddr;
    assign mem_wd = (r_state == S_CLEAR) ? '1 : wu_rsp.data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_waddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_free   <= '0;
            r_status <= ST_OK;
            r_faddr  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + WADDR_W'(1);
                    if (r_clr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_in_data.opcode;
                        r_addr   <= i_in_data.address;
                        r_end    <= i_in_data.range_end;
                        r_status <= ST_OK;
                        r_faddr  <= '0;
                        r_state  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    unique case (r_op)
                        OP_ALLOC: begin
                            r_waddr <= '0;
                            r_state <= S_ARD;
                        end
                        OP_FREE: begin
                            if (addr_x >= LIMIT) begin
                                r_status <= ST_LIMIT;
                                r_state  <= S_DONE;
                            end else if (r_addr[FB_LOG-1:0] != '0) begin
                                r_status <= ST_ALIGN;
                                r_state  <= S_DONE;
                            end else begin
                                r_waddr   <= WADDR_W'(first_f >> BIT_W);
                                r_first_w <= WADDR_W'(first_f >> BIT_W);
                                r_last_w  <= WADDR_W'(first_f >> BIT_W);
                                r_lo      <= first_f[BIT_W-1:0];
                                r_hi      <= first_f[BIT_W-1:0];
                                r_state   <= S_FRD;
                            end
                        end
                        default: begin
                            if (addr_x >= end_c) begin
                                r_state <= S_DONE;
                            end else begin
                                r_waddr   <= WADDR_W'(first_f >> BIT_W);
                                r_first_w <= WADDR_W'(first_f >> BIT_W);
                                r_last_w  <= WADDR_W'(lastm1_f >> BIT_W);
                                r_lo      <= first_f[BIT_W-1:0];
                                r_hi      <= lastm1_f[BIT_W-1:0];
                                r_state   <= S_RRD;
                            end
                        end
                    endcase
                end
                S_ARD: begin
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    if (wu_rsp.chg != '0) begin
                        r_free  <= r_free - CNT_W'(1);
                        r_faddr <= FADDR_W'({alloc_f, {FB_LOG{1'b0}}});
                        r_state <= S_DONE;
                    end else if (r_waddr == LAST_WORD) begin
                        r_status <= ST_EMPTY;
                        r_state  <= S_DONE;
                    end else begin
                        r_waddr <= r_waddr + WADDR_W'(1);
                        r_state <= S_ARD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (wu_rsp.chg == '0) begin
                        r_status <= ST_FREE;
                    end else begin
                        r_free <= r_free + CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_RRD: begin
                    r_state <= S_RMOD;
                end
                S_RMOD: begin
                    r_chg   <= wu_rsp.chg;
                    r_state <= S_RCNT;
                end
                S_RCNT: begin
                    if (r_op == OP_MARK_USED) begin
                        r_free <= r_free - CNT_W'(chg_cnt);
                    end else begin
                        r_free <= r_free + CNT_W'(chg_cnt);
                    end
                    if (r_waddr == r_last_w) begin
                        r_state <= S_DONE;
                    end else begin
                        r_waddr <= r_waddr + WADDR_W'(1);
                        r_state <= S_RRD;
                    end
                end
                S_DONE: begin
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_DONE);
    assign o_res.status        = r_status;
    assign o_res.frame_address = r_faddr;
    assign o_res.free_count    = r_free;
    assign o_res.used_count    = TOTAL - r_free;

    `BFA_ASSERT(a_ready_excl, i_clk, i_rst_n, !(o_in_ready && o_res_valid))
    `BFA_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    `BFA_ASSERT(a_write_state, i_clk, i_rst_n, mem_we |-> (r_state == S_CLEAR || r_state == S_ACHK || r_state == S_FCHK || r_state == S_RMOD))
    `BFA_ASSERT(a_no_rw, i_clk, i_rst_n, !(mem_we && mem_re))
endmodule
`default_nettype wire

@@ sv/bitmap_frame_allocator.sv @@
// First-fit page-frame allocator over a one-bit-per-frame used map.
// The input channel carries one transaction per operation: allocate, free one
// frame, or mark a byte range free or used. The output channel returns one
// transaction per operation with status, frame address and the free and used
// frame counts after the operation.
// The map is held as 32-bit words in a single-port memory and every operation
// is carried out one word at a time by a shared word unit.
// Allocate reads and checks the map word by word up to the first word with a
// free frame. Free reads and updates the one word of its frame; a rejected
// free ends without touching the map. A range operation reads, updates and
// counts every map word it touches. One operation is in flight at a time.
// After reset the map is filled with ones, one word per cycle, and no input
// is accepted until the fill is done.
// A finished result waits in an output register, so a stalled receiver lets
// the next operation be accepted; its result waits until that register drains.
`default_nettype none
module bitmap_frame_allocator #(
    parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF,
    parameter int FRAME_COUNT = bfa_pkg::FRAME_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bfa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfa_pkg::t_out_item o_out_data
);
    import bfa_pkg::*;

    logic      res_valid;
    logic      res_ack;
    logic      take;
    t_out_item res;
    logic      r_out_valid;
    t_out_item r_out_data;

    bfa_seq #(
        .FRAME_BYTES(FRAME_BYTES),
        .FRAME_COUNT(FRAME_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .o_res_valid(res_valid),
        .i_res_ack  (res_ack),
        .o_res      (res)
    );

    assign take    = !r_out_valid || i_out_ready;
    assign res_ack = res_valid && take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_valid;
        end
        if (res_ack) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule
`default_nettype wire

@@ tb/sv/bfa_alloc_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module bfa_alloc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bfa_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bfa_pkg::t_out_item i_out_data,
    output int                 o_errors,
    output int                 o_pending
);
    import bfa_pkg::*;

    localparam longint unsigned FB     = FRAME_BYTES_DEF;
    localparam longint unsigned NFRAME = FRAME_COUNT_DEF;
    localparam longint unsigned LIMIT  = FB * NFRAME;
    localparam int              NWORDS = (FRAME_COUNT_DEF + 31) / 32;

    logic [31:0]      used_words [NWORDS];
    logic [CNT_W-1:0] free_cnt;
    t_out_item        expected_q [$];

    function automatic logic frame_used(input longint unsigned f);
        return used_words[f / 32][f % 32];
    endfunction

    function automatic void set_frame(input longint unsigned f, input logic v);
        if (used_words[f / 32][f % 32] != v) begin
            used_words[f / 32][f % 32] = v;
            free_cnt = v ? free_cnt - 1'b1 : free_cnt + 1'b1;
        end
    endfunction

    function automatic t_out_item apply_op(input t_in_item it);
        t_out_item        r;
        longint unsigned  a;
        longint unsigned  e;
        longint unsigned  first;
        longint unsigned  last;
        longint unsigned  f;
        logic             found;
        r = '0;
        r.status = ST_OK;
        a = it.address;
        e = it.range_end;
        found = 1'b0;
        f = 0;
        case (it.opcode)
            OP_ALLOC: begin
                for (int w = 0; w < NWORDS; w++) begin
                    if (!found && used_words[w] != '1) begin
                        for (int k = 0; k < 32; k++) begin
                            if (!found && !used_words[w][k]) begin
                                found = 1'b1;
                                f = w * 32 + k;
                            end
                        end
                    end
                end
                if (found && f < NFRAME) begin
                    set_frame(f, 1'b1);
                    r.frame_address = FADDR_W'(f * FB);
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                if (a >= LIMIT) begin
                    r.status = ST_LIMIT;
                end else if (a % FB != 0) begin
                    r.status = ST_ALIGN;
                end else if (!frame_used(a / FB)) begin
                    r.status = ST_FREE;
                end else begin
                    set_frame(a / FB, 1'b0);
                end
            end
            default: begin
                if (e > LIMIT) begin
                    e = LIMIT;
                end
                if (a < e) begin
                    first = a / FB;
                    last = (e + FB - 1) / FB;
                    if (last > NFRAME) begin
                        last = NFRAME;
                    end
                    for (f = first; f < last; f++) begin
                        set_frame(f, it.opcode == OP_MARK_USED);
                    end
                end
            end
        endcase
        r.free_count = free_cnt;
        r.used_count = CNT_W'(NFRAME - free_cnt);
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned exp_v,
                                          input longint unsigned act_v);
        if (exp_v != act_v) begin
            o_errors++;
            if (o_errors <= 10) begin
                $display("Mismatch in %s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            for (int w = 0; w < NWORDS; w++) begin
                used_words[w] = '1;
            end
            free_cnt = '0;
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("Unexpected output transaction: 0x%0h", i_out_data);
                    end
                end else begin
                    exp_r = expected_q.pop_front();
                    compare_field("status", exp_r.status, i_out_data.status);
                    compare_field("frame_address", exp_r.frame_address,
                                  i_out_data.frame_address);
                    compare_field("free_count", exp_r.free_count, i_out_data.free_count);
                    compare_field("used_count", exp_r.used_count, i_out_data.used_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(apply_op(i_in_data));
            end
        end
        o_pending = expected_q.size();
    end
endmodule
`default_nettype wire

@@ tb/sv/tb_bitmap_frame_allocator.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int RANDOM_PER_PHASE = 112;
    localparam int CYCLE_LIMIT      = 40000000;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    int        n_errors;
    int        n_pending;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        op_count [4] = '{0, 0, 0, 0};
    int        cycles = 0;

    bitmap_frame_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    bfa_alloc_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_errors    (n_errors),
        .o_pending   (n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic t_in_item mk(input logic [1:0] op, input logic [31:0] a,
                                    input logic [31:0] e);
        t_in_item it;
        it.opcode = op;
        it.address = a;
        it.range_end = e;
        return it;
    endfunction

    task automatic send_op(input t_in_item it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        op_count[it.opcode]++;
    endtask

    function automatic t_in_item random_op();
        int          p;
        logic [31:0] a;
        logic [31:0] e;
        p = $urandom_range(99);
        a = $urandom;
        e = $urandom;
        if (p < 40) begin
            return mk(OP_ALLOC, a, e);
        end else if (p < 70) begin
            p = $urandom_range(9);
            if (p < 8) begin
                a = 32'($urandom_range(127)) << 12;
            end else if (p < 9) begin
                a = (32'($urandom_range(127)) << 12) | 32'($urandom_range(1, 4095));
            end
            return mk(OP_FREE, a, e);
        end else if (p < 92) begin
            a = 32'($urandom_range(32'h7FFFF));
            e = a + 32'($urandom_range(32'h8000));
        end else begin
            if (a < e && a < 32'h4000_0000 && e - a > 32'h40000) begin
                e = a + 32'($urandom_range(32'h40000));
            end
        end
        return mk($urandom_range(1) ? OP_MARK_FREE : OP_MARK_USED, a, e);
    endfunction

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(mk(OP_ALLOC, 32'h0, 32'h0));
        send_op(mk(OP_FREE, 32'h4000_0000, 32'h0));
        send_op(mk(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_op(mk(OP_FREE, 32'h0000_1001, 32'h0));
        send_op(mk(OP_FREE, 32'h0, 32'h0));
        send_op(mk(OP_FREE, 32'h0, 32'h0));
        send_op(mk(OP_ALLOC, 32'h0, 32'h0));
        send_op(mk(OP_FREE, 32'h3FFF_F000, 32'h0));
        send_op(mk(OP_MARK_FREE, 32'h0, 32'h1_0000));
        send_op(mk(OP_MARK_USED, 32'h3000, 32'h3001));
        send_op(mk(OP_MARK_FREE, 32'h5000, 32'h5000));
        send_op(mk(OP_MARK_USED, 32'h4000_0000, 32'hFFFF_FFFF));
        send_op(mk(OP_MARK_USED, 32'h9000, 32'h8000));
        send_op(mk(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_op(mk(OP_MARK_FREE, 32'h3FFF_E800, 32'hFFFF_FFFF));
        send_op(mk(OP_MARK_FREE, 32'h0, 32'hFFFF_FFFF));
        send_op(mk(OP_ALLOC, 32'h0, 32'h0));
        send_op(mk(OP_MARK_USED, 32'h0, 32'h4000_0000));
        send_op(mk(OP_ALLOC, 32'h0, 32'h0));
        send_op(mk(OP_FREE, 32'h3FFF_F000, 32'h0));
        send_op(mk(OP_MARK_FREE, 32'h0FFF, 32'h8_0000));
        send_op(mk(OP_ALLOC, 32'h0, 32'h0));

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 88 : (ph == 3) ? 33 : 0;
            stall_pct = (ph == 2) ? 88 : (ph == 3) ? 33 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_op(random_op());
            end
        end
        i_in_valid <= 1'b0;
        stall_pct = 0;

        @(negedge i_clk);
        while (n_pending != 0) @(negedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Ran %0d allocates, %0d single frees, %0d mark-free and %0d mark-used ranges",
                 op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_MARK_FREE],
                 op_count[OP_MARK_USED]);
        $display("under four idle and stall mixes, with %0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
